@@ src/infix_formula_calculator_top_assert.svh @@
// Assertion helpers for the calculator block.
`ifndef INFIX_FORMULA_CALCULATOR_TOP_ASSERT_SVH
`define INFIX_FORMULA_CALCULATOR_TOP_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define IFC_ASSERT_IMP(lbl, clk, rst_n, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define IFC_ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/ifc_pkg.sv @@
package ifc_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADOP   = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_RSVD    = 2'd3
  } status_e;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharStar  = 8'h2A;
  localparam logic [7:0] CharSlash = 8'h2F;

endpackage

@@ src/ifc_intf.sv @@
interface ifc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_line;
  modport source (output valid, char_code, end_of_line, input ready);
  modport sink (input valid, char_code, end_of_line, output ready);
endinterface

interface ifc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [1:0]         status;
  logic signed [31:0] left_operand;
  logic signed [31:0] right_operand;
  logic [1:0]         operation;
  modport source (output valid, value, status, left_operand, right_operand, operation,
                  input ready);
  modport sink (input valid, value, status, left_operand, right_operand, operation,
                output ready);
endinterface

@@ src/ifc_front.sv @@
module ifc_front
  import ifc_pkg::*;
#(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [7:0]   char_code_i,
  input  logic         end_of_line_i,
  output logic         job_valid_o,
  input  logic         job_ready_i,
  output logic [W-1:0] job_a_o,
  output logic [W-1:0] job_b_o,
  output op_e          job_op_o,
  output logic         job_bad_o
);

  typedef enum logic [3:0] {
    PH_FIRST  = 4'b0001,
    PH_SECOND = 4'b0010,
    PH_TAIL   = 4'b0100,
    PH_ERROR  = 4'b1000
  } phase_e;

  phase_e       phase_q, phase_d;
  logic [W-1:0] a_q, a_d, b_q, b_d;
  op_e          op_q, op_d;
  logic         digit, is_op;
  op_e          code;
  logic [W-1:0] dval;
  logic         fire;

  assign in_ready_o  = job_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign digit       = (char_code_i >= CharZero) && (char_code_i <= CharNine);
  assign dval        = W'(char_code_i - CharZero);

  always_comb begin
    is_op = 1'b1;
    code  = OP_ADD;
    unique case (char_code_i)
      CharPlus:  code = OP_ADD;
      CharMinus: code = OP_SUB;
      CharStar:  code = OP_MUL;
      CharSlash: code = OP_DIV;
      default:   is_op = 1'b0;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    a_d     = a_q;
    b_d     = b_q;
    op_d    = op_q;
    unique case (phase_q)
      PH_FIRST: begin
        if (digit) a_d = W'({a_q, 3'b0} + {a_q, 1'b0} + dval);
        else if (is_op) begin
          op_d    = code;
          phase_d = PH_SECOND;
        end else phase_d = PH_ERROR;
      end
      PH_SECOND: begin
        if (digit) b_d = W'({b_q, 3'b0} + {b_q, 1'b0} + dval);
        else phase_d = PH_TAIL;
      end
      default: ;
    endcase
  end

  // The job carries the state after this byte; the back end does the math.
  assign job_valid_o = fire && end_of_line_i;
  assign job_a_o     = a_d;
  assign job_bad_o   = (phase_d == PH_ERROR) || (phase_d == PH_FIRST);
  assign job_b_o     = job_bad_o ? '0 : b_d;
  assign job_op_o    = job_bad_o ? OP_ADD : op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      a_q     <= '0;
      b_q     <= '0;
      op_q    <= OP_ADD;
    end else if (fire) begin
      if (end_of_line_i) begin
        phase_q <= PH_FIRST;
        a_q     <= '0;
        b_q     <= '0;
        op_q    <= OP_ADD;
      end else begin
        phase_q <= phase_d;
        a_q     <= a_d;
        b_q     <= b_d;
        op_q    <= op_d;
      end
    end
  end

endmodule

@@ src/ifc_queue.sv @@
module ifc_queue #(
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  logic [DW-1:0] wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign wr         = wr_valid_i && wr_ready_o;
  assign rd         = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

@@ src/ifc_back.sv @@
module ifc_back
  import ifc_pkg::*;
#(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         job_valid_i,
  output logic         job_ready_o,
  input  logic [W-1:0] job_a_i,
  input  logic [W-1:0] job_b_i,
  input  op_e          job_op_i,
  input  logic         job_bad_i,
  output logic         res_valid_o,
  input  logic         res_ready_i,
  output logic [W-1:0] res_value_o,
  output status_e      res_status_o,
  output logic [W-1:0] res_a_o,
  output logic [W-1:0] res_b_o,
  output op_e          res_op_o
);

  `include "infix_formula_calculator_top_assert.svh"

  localparam int unsigned CW = $clog2(W + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  state_e          state_q;
  logic [W-1:0]    a_q, b_q, val_q, rem_q, quo_q, dvs_q;
  op_e             op_q;
  status_e         st_q;
  logic            neg_q;
  logic [CW-1:0]   cnt_q;
  logic [W-1:0]    ma, mb, sum;
  logic [2*W-1:0]  prod;
  logic [W:0]      trial;
  logic [W-1:0]    rsh;

  assign job_ready_o = state_q == S_IDLE;
  assign res_valid_o = state_q == S_OUT;
  assign res_value_o = val_q;
  assign res_status_o = st_q;
  assign res_a_o     = a_q;
  assign res_b_o     = b_q;
  assign res_op_o    = op_q;

  assign ma    = job_a_i[W-1] ? W'(-job_a_i) : job_a_i;
  assign mb    = job_b_i[W-1] ? W'(-job_b_i) : job_b_i;
  assign prod  = job_a_i * job_b_i;
  assign sum   = (job_op_i == OP_SUB) ? W'(job_a_i - job_b_i) : W'(job_a_i + job_b_i);
  // One restoring step: shift in the next dividend bit and try the divisor.
  assign rsh   = {rem_q[W-2:0], quo_q[W-1]};
  assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_ready_o) begin
      a_q   <= job_a_i;
      b_q   <= job_b_i;
      op_q  <= job_op_i;
      neg_q <= job_a_i[W-1] ^ job_b_i[W-1];
      rem_q <= '0;
      quo_q <= ma;
      dvs_q <= mb;
      val_q <= '0;
      st_q  <= ST_OK;
      if (job_bad_i) st_q <= ST_BADOP;
      else if (job_op_i == OP_MUL) val_q <= prod[W-1:0];
      else if (job_op_i == OP_DIV) begin
        if (job_b_i == '0) st_q <= ST_DIVZERO;
      end else val_q <= sum;
    end else if (state_q == S_DIV) begin
      if (!trial[W]) begin
        rem_q <= trial[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= rsh;
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
      if (cnt_q == CW'(1)) begin
        if (!trial[W]) val_q <= neg_q ? W'(-{quo_q[W-2:0], 1'b1}) : {quo_q[W-2:0], 1'b1};
        else val_q <= neg_q ? W'(-{quo_q[W-2:0], 1'b0}) : {quo_q[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: if (job_valid_i) begin
          if (!job_bad_i && job_op_i == OP_DIV && job_b_i != '0) begin
            state_q <= S_DIV;
            cnt_q   <= CW'(W);
          end else state_q <= S_OUT;
        end
        S_DIV: begin
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == CW'(1)) state_q <= S_OUT;
        end
        S_OUT: if (res_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `IFC_ASSERT_IMP(a_div_cnt, clk_i, rst_ni, state_q == S_DIV, cnt_q != '0)
  `IFC_ASSERT_IMP(a_err_zero, clk_i, rst_ni, res_valid_o && st_q != ST_OK, val_q == '0)
  `IFC_ASSERT_NEXT(a_div_done, clk_i, rst_ni, state_q == S_DIV && cnt_q == CW'(1),
                   state_q == S_OUT)

endmodule

@@ src/infix_formula_calculator_top.sv @@
// Two-operand decimal infix calculator ("12+34", "7/-" ...).
// Input channel in_if: one ASCII byte per beat in char_code, with end_of_line
// marking the last byte of a formula. Output channel out_if: one beat per
// formula carrying value, status (ok, bad operator, divide by zero), both
// operands as parsed and the operation code.
// Rate: the front parser takes one byte per cycle while the queue has room.
// A formula end hands a job through a two-entry queue to the back end, which
// computes add, subtract, multiply or error results as it takes the job, or
// runs a restoring divide (one quotient bit per cycle), then shows the result.
// Reset clears the parser to "reading first number", empties the queue and
// idles the back end. When the receiver stalls, the result holds on the
// output; the queue fills and the front then stops taking bytes.
module infix_formula_calculator_top
  import ifc_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input logic      clk_i,
  input logic      rst_ni,
  ifc_in_if.sink   in_if,
  ifc_out_if.source out_if
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned DW = 2 * W + 3;

  logic         f_valid, f_ready, b_valid, b_ready, r_valid;
  logic [W-1:0] f_a, f_b, b_a, b_b;
  op_e          f_op, b_op, r_op;
  logic         f_bad, b_bad;
  logic [DW-1:0] q_in, q_out;
  logic [W-1:0] r_val, r_a, r_b;
  status_e      r_st;

  ifc_front #(.W(W)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .char_code_i(in_if.char_code), .end_of_line_i(in_if.end_of_line),
    .job_valid_o(f_valid), .job_ready_i(f_ready),
    .job_a_o(f_a), .job_b_o(f_b), .job_op_o(f_op), .job_bad_o(f_bad)
  );

  assign q_in = {f_a, f_b, f_op, f_bad};

  ifc_queue #(.DW(DW)) u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(q_in),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(q_out)
  );

  assign b_a   = q_out[DW-1 -: W];
  assign b_b   = q_out[W+2 -: W];
  assign b_op  = op_e'(q_out[2:1]);
  assign b_bad = q_out[0];

  ifc_back #(.W(W)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(b_valid), .job_ready_o(b_ready),
    .job_a_i(b_a), .job_b_i(b_b), .job_op_i(b_op), .job_bad_i(b_bad),
    .res_valid_o(r_valid), .res_ready_i(out_if.ready),
    .res_value_o(r_val), .res_status_o(r_st), .res_a_o(r_a), .res_b_o(r_b),
    .res_op_o(r_op)
  );

  // Words are VALUE_WIDTH bits wide; zero-extend or truncate to the 32-bit fields.
  assign out_if.valid         = r_valid;
  assign out_if.value         = 32'(r_val);
  assign out_if.status        = r_st;
  assign out_if.left_operand  = 32'(r_a);
  assign out_if.right_operand = 32'(r_b);
  assign out_if.operation     = r_op;

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  import ifc_pkg::*;

  typedef struct packed {
    logic signed [31:0] value;
    status_e            status;
    logic signed [31:0] left_operand;
    logic signed [31:0] right_operand;
    op_e                operation;
  } calc_result_t;

  logic clk_i;
  logic rst_ni;

  ifc_in_if  in_if ();
  ifc_out_if out_if ();

  infix_formula_calculator_top #(.VALUE_WIDTH(32)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  // Calculator state mirrored for prediction.
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_TAIL   = 2'd2,
    PH_ERROR  = 2'd3
  } parse_phase_e;

  parse_phase_e calc_phase;
  logic [31:0]  first_acc;
  logic [31:0]  second_acc;
  op_e          pending_op;
  logic         bad_op_seen;

  calc_result_t formula_results_q[$];
  int unsigned  fail_count;
  int unsigned  results_seen;
  int unsigned  bytes_sent;

  // Receiver stall control.
  bit          stall_enable;
  int unsigned hold_off_cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #40000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic bit is_digit(logic [7:0] c);
    return c >= CharZero && c <= CharNine;
  endfunction

  function automatic void clear_parser();
    calc_phase  = PH_FIRST;
    first_acc   = '0;
    second_acc  = '0;
    pending_op  = OP_ADD;
    bad_op_seen = 1'b0;
  endfunction

  // Advance the parser by one byte; push an expected result at end of line.
  function automatic void predict_formula_byte(logic [7:0] c, logic eol);
    calc_result_t r;
    logic [31:0]  a, b, qa, qb, q;
    a = '0; b = '0; qa = '0; qb = '0; q = '0;
    case (calc_phase)
      PH_FIRST: begin
        if (is_digit(c)) first_acc = first_acc * 10 + (c - CharZero);
        else if (c == CharPlus)  begin pending_op = OP_ADD; calc_phase = PH_SECOND; end
        else if (c == CharMinus) begin pending_op = OP_SUB; calc_phase = PH_SECOND; end
        else if (c == CharStar)  begin pending_op = OP_MUL; calc_phase = PH_SECOND; end
        else if (c == CharSlash) begin pending_op = OP_DIV; calc_phase = PH_SECOND; end
        else begin
          bad_op_seen = 1'b1;
          calc_phase  = PH_ERROR;
        end
      end
      PH_SECOND: begin
        if (is_digit(c)) second_acc = second_acc * 10 + (c - CharZero);
        else calc_phase = PH_TAIL;
      end
      default: ;
    endcase
    if (!eol) return;
    a = first_acc;
    b = second_acc;
    r.left_operand = a;
    r.status       = ST_OK;
    r.value        = '0;
    if (bad_op_seen || calc_phase == PH_FIRST) begin
      // Missing or bad operator: drop the second number and the operation.
      r.status        = ST_BADOP;
      r.right_operand = '0;
      r.operation     = OP_ADD;
    end else begin
      r.right_operand = b;
      r.operation     = pending_op;
      case (pending_op)
        OP_ADD: r.value = a + b;
        OP_SUB: r.value = a - b;
        OP_MUL: r.value = a * b;
        default: begin
          if (b == 0) r.status = ST_DIVZERO;
          else begin
            qa = a[31] ? -a : a;
            qb = b[31] ? -b : b;
            q  = qa / qb;
            r.value = (a[31] != b[31]) ? -q : q;
          end
        end
      endcase
    end
    formula_results_q.push_back(r);
    clear_parser();
  endfunction

  // Send one byte; waits for acceptance, with random inter-burst gaps.
  int unsigned burst_left;

  task automatic send_byte(logic [7:0] c, logic eol);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_if.valid       <= 1'b1;
    in_if.char_code   <= c;
    in_if.end_of_line <= eol;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_formula_byte(c, eol);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_number(logic [31:0] v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] pick_op_char();
    case ($urandom_range(0, 3))
      0: return CharPlus;
      1: return CharMinus;
      2: return CharStar;
      default: return CharSlash;
    endcase
  endfunction

  function automatic logic [7:0] pick_noise_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic idle_input();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (formula_results_q.size() != 0) @(negedge clk_i);
  endtask

  // Directed: one of each operation, extremes, and each special case.
  task automatic test_directed();
    send_text("12+34");
    send_text("100-250");
    send_text("7*6");
    send_text("99/7");
    send_text("4294967295+1");   // sum wraps to zero
    send_text("2147483648/9");   // negative left operand
    send_text("2147483648/4294967295"); // most negative by minus one
    send_text("5/0");            // divide by zero
    send_text("5/");             // no second digits: divide by zero
    send_text("8+");             // no second digits
    send_text("12a3");           // bad operator
    send_text("42");             // line ends before operator
    send_text("+");              // operator first, empty operands
    send_text("9*9 trailing");   // tail ignored
    send_text("99999999999*99999999999");
  endtask

  // Random well-formed formulas with random content; some noise and broken ones.
  task automatic test_random(int unsigned n_bytes);
    int unsigned start;
    int unsigned kind;
    logic [31:0] v;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        v = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 999);
        send_number(v);
        send_byte(pick_op_char(), 1'b0);
        v = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : $urandom_range(0, 9999);
        if ($urandom_range(0, 7) != 0) send_number(v);
        if ($urandom_range(0, 4) == 0) send_byte(pick_noise_char(), 1'b0);
        send_byte(($urandom_range(0, 1) == 0) ? 8'(CharZero + $urandom_range(0, 9))
                                              : pick_noise_char(), 1'b1);
      end else begin
        // Noise: random bytes, end of line at random.
        for (int i = $urandom_range(1, 8); i > 0; i--) begin
          send_byte(pick_noise_char(), i == 1 || $urandom_range(0, 9) == 0);
        end
      end
    end
    idle_input();
  endtask

  // Hold the receiver off while bytes keep coming, so the queue fills.
  task automatic test_backpressure();
    hold_off_cycles = 400;
    for (int i = 0; i < 12; i++) send_text("3*4");
    wait (hold_off_cycles == 0);
    idle_input();
  endtask

  // Receiver: own stall pattern, plus hold-off counting.
  initial begin
    int unsigned phase_cnt;
    out_if.ready = 1'b0;
    phase_cnt = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles != 0) begin
        hold_off_cycles--;
        out_if.ready <= 1'b0;
      end else if (!stall_enable) begin
        out_if.ready <= 1'b1;
      end else begin
        phase_cnt++;
        out_if.ready <= (phase_cnt % 7 < 4) ? ($urandom_range(0, 3) != 0) : (phase_cnt[5]);
      end
    end
  end

  // Result checker.
  initial begin
    calc_result_t got, exp_r;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got.value         = out_if.value;
        got.status        = status_e'(out_if.status);
        got.left_operand  = out_if.left_operand;
        got.right_operand = out_if.right_operand;
        got.operation     = op_e'(out_if.operation);
        results_seen++;
        if (formula_results_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          exp_r = formula_results_q.pop_front();
          if (got.value !== exp_r.value) begin
            $error("value: expected %0d got %0d", exp_r.value, got.value);
            fail_count++;
          end
          if (got.status !== exp_r.status) begin
            $error("status: expected %0d got %0d", exp_r.status, got.status);
            fail_count++;
          end
          if (got.left_operand !== exp_r.left_operand) begin
            $error("left_operand: expected %0d got %0d", exp_r.left_operand,
                   got.left_operand);
            fail_count++;
          end
          if (got.right_operand !== exp_r.right_operand) begin
            $error("right_operand: expected %0d got %0d", exp_r.right_operand,
                   got.right_operand);
            fail_count++;
          end
          if (got.operation !== exp_r.operation) begin
            $error("operation: expected %0d got %0d", exp_r.operation, got.operation);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    int unsigned guard;
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.char_code   = '0;
    in_if.end_of_line = 1'b0;
    fail_count        = 0;
    results_seen      = 0;
    bytes_sent        = 0;
    burst_left        = 0;
    stall_enable      = 1'b0;
    hold_off_cycles   = 0;
    clear_parser();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    stall_enable = 1'b1;
    test_random(850);
    test_backpressure();
    test_random(650);
    stall_enable = 1'b0;
    test_random(220);

    guard = 0;
    while (formula_results_q.size() != 0 && guard < 100000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (80) @(negedge clk_i);
    if (fail_count == 0 && formula_results_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/ifc_pkg.sv
src/ifc_intf.sv
src/ifc_front.sv
src/ifc_queue.sv
src/ifc_back.sv
src/infix_formula_calculator_top.sv
tb/tb_top.sv
